FILE: rtl/ipv4rx_pkg.sv
package ipv4rx_pkg;

  typedef enum logic [3:0] {
    V_WHOLE   = 4'd0,
    V_REASM   = 4'd1,
    V_FORWARD = 4'd2,
    V_STOPPED = 4'd3,
    V_SHORT   = 4'd4,
    V_VERSION = 4'd5,
    V_HDRLEN  = 4'd6,
    V_CHKSUM  = 4'd7,
    V_TOTLEN  = 4'd8,
    V_NOTADDR = 4'd9
  } verdict_e;

  localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] CFG_ROUTING_EN = 2'd1;
  localparam logic [1:0] CFG_IF_STOPPED = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Header fields and frame totals as they stand after the final byte.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [16:0] csum;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [15:0] frag_word;
    logic [7:0]  ttl;
    logic [31:0] dest;
  } hdr_snap_t;

endpackage

FILE: rtl/ipv4rx_in_if.sv
interface ipv4rx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

FILE: rtl/ipv4rx_out_if.sv
interface ipv4rx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [5:0]  header_length;
  logic [15:0] payload_length;
  logic [7:0]  ttl_out;

  modport source (output valid, output verdict, output header_length,
                  output payload_length, output ttl_out, input ready);
  modport sink   (input valid, input verdict, input header_length,
                  input payload_length, input ttl_out, output ready);
endinterface

FILE: rtl/ipv4rx_hdr_acc.sv
module ipv4rx_hdr_acc
  import ipv4rx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output hdr_snap_t  snap_o
);

  logic [15:0] cnt_q, cnt_d;
  logic [16:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  vihl_q, vihl_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [31:0] dest_q, dest_d;
  logic [5:0]  hlen;
  logic [15:0] word;

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    hold_d = hold_q;
    vihl_d = vihl_q;
    tlen_d = tlen_q;
    frag_d = frag_q;
    ttl_d  = ttl_q;
    dest_d = dest_q;

    if (cnt_q == 16'd0) begin
      vihl_d = byte_i;
    end
    hlen = {vihl_d[3:0], 2'b00};
    word = {hold_q, byte_i};

    if (cnt_q < {10'd0, hlen}) begin
      if (!cnt_q[0]) begin
        hold_d = byte_i;
      end else begin
        sum_d = {1'b0, sum_q[15:0]} + {16'd0, sum_q[16]} + {1'b0, word};
      end
    end

    case (cnt_q)
      16'd2:   tlen_d = {byte_i, tlen_q[7:0]};
      16'd3:   tlen_d = {tlen_q[15:8], byte_i};
      16'd6:   frag_d = {byte_i, frag_q[7:0]};
      16'd7:   frag_d = {frag_q[15:8], byte_i};
      16'd8:   ttl_d  = byte_i;
      16'd16, 16'd17, 16'd18, 16'd19: dest_d = {dest_q[23:0], byte_i};
      default: ;
    endcase

    // saturates: the frame length is taken as 65535 beyond that
    if (cnt_q != 16'hFFFF) begin
      cnt_d = cnt_q + 16'd1;
    end

    snap_o.frame_len = cnt_d;
    snap_o.csum      = sum_d;
    snap_o.ver_ihl   = vihl_d;
    snap_o.total_len = tlen_d;
    snap_o.frag_word = frag_d;
    snap_o.ttl       = ttl_d;
    snap_o.dest      = dest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      hold_q <= '0;
      vihl_q <= '0;
      tlen_q <= '0;
      frag_q <= '0;
      ttl_q  <= '0;
      dest_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        hold_q <= '0;
        vihl_q <= '0;
        tlen_q <= '0;
        frag_q <= '0;
        ttl_q  <= '0;
        dest_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        hold_q <= hold_d;
        vihl_q <= vihl_d;
        tlen_q <= tlen_d;
        frag_q <= frag_d;
        ttl_q  <= ttl_d;
        dest_q <= dest_d;
      end
    end
  end

endmodule

FILE: rtl/ipv4_receive_header_classifier.sv
// IPv4 receive header classifier.
// Throughput: one packet byte per cycle, including back-to-back frames, except
//   when the output stalls and both snapshot and result stages are full.
// Each frame passes the header snapshot register, then the result register.
// Reset (rst_ni, async, active low) clears the accumulator, the config registers
//   and both valid flags (not snapshot/result data); no clearing pass is needed.
module ipv4_receive_header_classifier
  import ipv4rx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ipv4rx_in_if.sink           in_if,
  ipv4rx_out_if.source        out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers. User writes only while block is idle; not enforced.
  // ---------------------------------------------------------------------
  logic [31:0] local_addr_q;
  logic        routing_en_q;
  logic        if_stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      routing_en_q <= 1'b0;
      if_stopped_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_ADDR: local_addr_q <= cfg_data_i[31:0];
        CFG_ROUTING_EN: routing_en_q <= cfg_data_i[0];
        CFG_IF_STOPPED: if_stopped_q <= cfg_data_i[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. Three-deep flow: byte accumulator -> snapshot -> result.
  // The snapshot moves on whenever the result register is empty or
  // being drained, so input stalls only when both stages are full.
  // ---------------------------------------------------------------------
  logic      in_acc;
  logic      out_free;
  logic      snap_adv;
  logic      snap_vld_q;
  hdr_snap_t snap_next;
  hdr_snap_t snap_q;

  assign out_free    = !out_if.valid || out_if.ready;
  assign snap_adv    = snap_vld_q && out_free;
  assign in_if.ready = !snap_vld_q || snap_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  // Per-byte accumulation: count, header checksum, field capture.
  ipv4rx_hdr_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_if.byte_value),
    .last_i   (in_if.last_byte),
    .snap_o   (snap_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else if (in_acc && in_if.last_byte) begin
      snap_vld_q <= 1'b1;
    end else if (snap_adv) begin
      snap_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.last_byte) begin
      snap_q <= snap_next;
    end
  end

  // ---------------------------------------------------------------------
  // Verdict logic on the snapshot.
  // ---------------------------------------------------------------------
  logic [5:0]  hlen;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic        csum_ok;
  logic        addressed;
  verdict_e    verdict;
  logic [15:0] payload;
  logic [7:0]  ttl_res;

  always_comb begin
    hlen    = {snap_q.ver_ihl[3:0], 2'b00};
    // two end-around-carry folds of the 17-bit running sum
    fold1   = {1'b0, snap_q.csum[15:0]} + {16'd0, snap_q.csum[16]};
    fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    csum_ok = (fold2 == 17'h0FFFF);
    // all-ones destination is treated as broadcast
    addressed = (snap_q.dest == local_addr_q) || (snap_q.dest == 32'hFFFF_FFFF);
    payload = snap_q.total_len - {10'd0, hlen};
    ttl_res = snap_q.ttl;

    if (if_stopped_q) begin
      verdict = V_STOPPED;
    end else if (snap_q.frame_len < 16'd20) begin
      verdict = V_SHORT;
    end else if (snap_q.ver_ihl[7:4] != 4'd4) begin
      verdict = V_VERSION;
    end else if ({10'd0, hlen} > snap_q.frame_len) begin
      verdict = V_HDRLEN;
    end else if (!csum_ok) begin
      verdict = V_CHKSUM;
    end else if (snap_q.total_len > snap_q.frame_len) begin
      verdict = V_TOTLEN;
    end else if (!addressed) begin
      if (!routing_en_q || snap_q.ttl == 8'd0) begin
        verdict = V_NOTADDR;
      end else begin
        verdict = V_FORWARD;
        ttl_res = snap_q.ttl - 8'd1;
      end
    end else if (snap_q.frag_word[13:0] == 14'd0) begin
      // MF clear and offset zero
      verdict = V_WHOLE;
    end else begin
      verdict = V_REASM;
    end

    // drop verdicts report no payload and no TTL
    if (verdict != V_WHOLE && verdict != V_REASM && verdict != V_FORWARD) begin
      payload = '0;
      ttl_res = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  logic        out_vld_q;
  logic [3:0]  out_verdict_q;
  logic [5:0]  out_hlen_q;
  logic [15:0] out_payload_q;
  logic [7:0]  out_ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (snap_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv) begin
      out_verdict_q <= verdict;
      out_hlen_q    <= hlen;
      out_payload_q <= payload;
      out_ttl_q     <= ttl_res;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.verdict        = out_verdict_q;
  assign out_if.header_length  = out_hlen_q;
  assign out_if.payload_length = out_payload_q;
  assign out_if.ttl_out        = out_ttl_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Input backpressure only when both snapshot and result stages are full.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (snap_vld_q && out_vld_q))
    else $error("input stalled with a free stage");

  // A last-byte transaction always lands in the snapshot stage.
  a_last_to_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_if.last_byte) |=> snap_vld_q)
    else $error("final byte lost before snapshot");

  // Drop verdicts carry zero payload length and TTL.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_verdict_q != V_WHOLE && out_verdict_q != V_REASM &&
     out_verdict_q != V_FORWARD) |-> (out_payload_q == 16'd0 && out_ttl_q == 8'd0))
    else $error("drop verdict with nonzero payload or ttl");

endmodule

FILE: verif/tb_ipv4_receive_header_classifier.sv
`timescale 1ns / 100ps

module tb_ipv4_receive_header_classifier;
  import ipv4rx_pkg::*;

  // unmapped register index, writes there must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [3:0]  IPV4_VERSION  = 4'd4;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd20;
  localparam int          HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int          DRAIN_CYCLES  = 8;    // covers the snapshot and result register stages
  localparam int          MAX_PRINTS    = 100;

  localparam logic [31:0] LOCAL_A = 32'hC0A8_0001;

  // one byte transaction on the input channel
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } rx_byte_t;

  // one verdict transaction on the output channel
  typedef struct {
    verdict_e    verdict;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic [7:0]  ttl_out;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // all block inputs start known at time zero
  logic                tx_valid   = 1'b0;
  logic [7:0]          tx_byte    = '0;
  logic                tx_last    = 1'b0;
  logic                rx_ready   = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ipv4rx_in_if  in_ch ();
  ipv4rx_out_if out_ch ();

  assign in_ch.valid      = tx_valid;
  assign in_ch.byte_value = tx_byte;
  assign in_ch.last_byte  = tx_last;
  assign out_ch.ready     = rx_ready;

  ipv4_receive_header_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Global watchdog. The slowest legal run (about 1500 throttled bytes plus one
  // long hold-off) ends well before it fires.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus store, knobs, scoreboard
  // ---------------------------------------------------------------------------
  rx_byte_t byte_q[$];      // bytes waiting to be offered
  verdict_t verdict_q[$];   // verdicts predicted, not yet seen
  int       queued_total = 0;
  int       err_count    = 0;
  int       verdicts_seen = 0;

  int send_idle_pct  = 0;   // % of free cycles the sender leaves empty
  int recv_stall_pct = 0;   // % of cycles the receiver drops ready
  int rx_hold_reqs   = 0;   // bumped to request one long hold-off

  // register mirror
  logic [31:0] cfg_local   = '0;
  logic        cfg_routing = 1'b0;
  logic        cfg_stopped = 1'b0;

  // packet state mirror
  logic [15:0] pkt_count   = '0;
  logic [16:0] pkt_sum     = '0;
  logic [7:0]  pkt_hi_byte = '0;
  logic [7:0]  pkt_ver_ihl = '0;
  logic [15:0] pkt_total   = '0;
  logic [15:0] pkt_frag    = '0;
  logic [7:0]  pkt_ttl     = '0;
  logic [31:0] pkt_dest    = '0;

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS)
      $display("tb: mismatch at verdict %0d: %s", verdicts_seen, what);
    err_count++;
  endtask

  // Advance the header mirror by one accepted byte; on the last byte,
  // work out the verdict and queue it.
  task automatic classify_byte(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    logic [5:0]  hlen;
    logic [15:0] len;
    logic [17:0] fold;
    verdict_t    res;
    idx = pkt_count;
    if (idx == 16'd0) pkt_ver_ihl = b;
    hlen = {pkt_ver_ihl[3:0], 2'b00};

    // ones-complement sum over the IHL-covered bytes only, end-around carry
    if (idx < {10'd0, hlen}) begin
      if (!idx[0]) pkt_hi_byte = b;
      else pkt_sum = {1'b0, pkt_sum[15:0]} + {16'd0, pkt_sum[16]} + {1'b0, pkt_hi_byte, b};
    end

    // field capture; nothing is captured once the counter is pinned
    case (idx)
      16'd2:  pkt_total[15:8] = b;
      16'd3:  pkt_total[7:0]  = b;
      16'd6:  pkt_frag[15:8]  = b;
      16'd7:  pkt_frag[7:0]   = b;
      16'd8:  pkt_ttl         = b;
      16'd16, 16'd17, 16'd18, 16'd19: pkt_dest = {pkt_dest[23:0], b};
      default: ;
    endcase

    // byte counter saturates, long frames read as 65535 bytes
    if (pkt_count != 16'hFFFF) pkt_count++;

    if (last) begin
      len  = pkt_count;
      fold = {2'b00, pkt_sum[15:0]} + {17'd0, pkt_sum[16]};
      fold = {2'b00, fold[15:0]} + {17'd0, fold[16]};
      res.header_length  = hlen;
      res.payload_length = pkt_total - {10'd0, hlen};
      res.ttl_out        = pkt_ttl;

      if (cfg_stopped)                         res.verdict = V_STOPPED;
      else if (len < MIN_FRAME_LEN)            res.verdict = V_SHORT;
      else if (pkt_ver_ihl[7:4] != IPV4_VERSION) res.verdict = V_VERSION;
      else if ({10'd0, hlen} > len)            res.verdict = V_HDRLEN;
      else if (fold != 18'h0FFFF)              res.verdict = V_CHKSUM;
      else if (pkt_total > len)                res.verdict = V_TOTLEN;
      else if (pkt_dest != cfg_local && pkt_dest != 32'hFFFF_FFFF) begin
        // not ours and not broadcast: forward only if routing and TTL allow
        if (!cfg_routing || pkt_ttl == 8'd0) begin
          res.verdict = V_NOTADDR;
        end else begin
          res.verdict = V_FORWARD;
          res.ttl_out = pkt_ttl - 8'd1;
        end
      end else if (pkt_frag[13:0] == '0)       res.verdict = V_WHOLE;  // no MF, no offset
      else                                     res.verdict = V_REASM;

      if (res.verdict >= V_STOPPED) begin
        res.payload_length = '0;
        res.ttl_out        = '0;
      end
      verdict_q.push_back(res);

      pkt_count   = '0;
      pkt_sum     = '0;
      pkt_hi_byte = '0;
      pkt_ver_ihl = '0;
      pkt_total   = '0;
      pkt_frag    = '0;
      pkt_ttl     = '0;
      pkt_dest    = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on each accepted transaction.
  // valid is only touched when the slot is free, so it never toggles
  // twice in one step.
  // ---------------------------------------------------------------------------
  rx_byte_t tx_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_byte  <= '0;
      tx_last  <= 1'b0;
    end else begin
      if (tx_valid && in_ch.ready) classify_byte(tx_byte, tx_last);
      if (!tx_valid || in_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tx_next = byte_q.pop_front();
          tx_valid <= 1'b1;
          tx_byte  <= tx_next.value;
          tx_last  <= tx_next.last;
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each verdict transaction against the oldest prediction
  // and throttles ready. A long hold-off is counted here.
  // ---------------------------------------------------------------------------
  verdict_t got_want;
  int       hold_left = 0;
  int       hold_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict %0d", out_ch.verdict));
        end else begin
          got_want = verdict_q.pop_front();
          if (out_ch.verdict !== got_want.verdict)
            report_mismatch($sformatf("verdict got %0d want %0d",
                                      out_ch.verdict, got_want.verdict));
          if (out_ch.header_length !== got_want.header_length)
            report_mismatch($sformatf("header_length got %0d want %0d",
                                      out_ch.header_length, got_want.header_length));
          if (out_ch.payload_length !== got_want.payload_length)
            report_mismatch($sformatf("payload_length got %0d want %0d",
                                      out_ch.payload_length, got_want.payload_length));
          if (out_ch.ttl_out !== got_want.ttl_out)
            report_mismatch($sformatf("ttl_out got %0d want %0d",
                                      out_ch.ttl_out, got_want.ttl_out));
        end
        verdicts_seen++;
      end
      if (hold_seen != rx_hold_reqs) begin
        hold_seen = rx_hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] value, input logic last);
    rx_byte_t item;
    item.value = value;
    item.last  = last;
    byte_q.push_back(item);
    queued_total++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOCAL_ADDR: cfg_local   = data;
      CFG_ROUTING_EN: cfg_routing = data[0];
      CFG_IF_STOPPED: cfg_stopped = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] addr, input logic [31:0] route,
                              input logic [31:0] stop);
    write_reg(CFG_LOCAL_ADDR, addr);
    write_reg(CFG_ROUTING_EN, route);
    write_reg(CFG_IF_STOPPED, stop);
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding,
  // then a further wait on the clock for the pipeline to settle.
  task automatic drain();
    while (byte_q.size() != 0 || tx_valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Header with random filler; checksum patched into bytes 10-11 when the header
  // covers them, the frame holds the whole header and fix_csum is set.
  task automatic queue_frame(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tot_len, input logic [15:0] frag,
                             input logic [7:0] ttl, input logic [31:0] dest,
                             input int frame_len, input bit fix_csum);
    logic [7:0]  fb[];
    logic [31:0] acc;
    int          hlen;
    int          k;
    fb   = new[frame_len];
    hlen = ihl * 4;
    for (k = 0; k < frame_len; k++) fb[k] = 8'($urandom_range(255));
    fb[0] = {ver, ihl};
    if (frame_len > 3) begin
      fb[2] = tot_len[15:8];
      fb[3] = tot_len[7:0];
    end
    if (frame_len > 8) begin
      fb[6] = frag[15:8];
      fb[7] = frag[7:0];
      fb[8] = ttl;
    end
    if (frame_len > 19) begin
      fb[16] = dest[31:24];
      fb[17] = dest[23:16];
      fb[18] = dest[15:8];
      fb[19] = dest[7:0];
    end
    if (fix_csum && hlen >= 12 && frame_len >= hlen) begin
      fb[10] = '0;
      fb[11] = '0;
      acc = '0;
      for (k = 0; k < hlen; k += 2) acc += {16'd0, fb[k], fb[k+1]};
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      fb[10] = ~acc[15:8];
      fb[11] = ~acc[7:0];
    end
    for (k = 0; k < frame_len; k++) push_byte(fb[k], k == frame_len - 1);
  endtask

  // Mostly well-formed headers with random content, some noise.
  task automatic queue_random_frame();
    int          pick;
    int          n;
    int          hlen;
    int          frame_len;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [7:0]  ttl;
    logic [31:0] dest;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // raw noise, often shorter than a minimum header
      n = $urandom_range(1, 48);
      for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), k == n - 1);
    end else begin
      ver = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : IPV4_VERSION;
      ihl = ($urandom_range(99) < 70) ? 4'd5 : 4'($urandom_range(15));
      hlen = ihl * 4;
      frame_len = ((hlen > 20) ? hlen : 20) + $urandom_range(12);
      if ($urandom_range(19) == 0) frame_len = $urandom_range(1, hlen + 4);

      pick = $urandom_range(99);
      if (pick < 75)      tot = 16'(frame_len);
      else if (pick < 85) tot = 16'($urandom_range(frame_len));
      else if (pick < 95) tot = 16'(frame_len + $urandom_range(1, 300));
      else                tot = 16'($urandom_range(16'hFFFF));

      pick = $urandom_range(99);
      if (pick < 40)      frag = 16'h0000;
      else if (pick < 60) frag = 16'h4000;                       // DF only
      else if (pick < 75) frag = 16'h2000 | 16'($urandom_range(16'hFFFF));
      else if (pick < 90) frag = 16'($urandom_range(16'h1FFF));
      else                frag = 16'($urandom_range(16'hFFFF));

      pick = $urandom_range(99);
      if (pick < 10)      ttl = 8'd0;
      else if (pick < 15) ttl = 8'd1;
      else if (pick < 20) ttl = 8'hFF;
      else                ttl = 8'($urandom_range(255));

      pick = $urandom_range(99);
      if (pick < 45)      dest = cfg_local;
      else if (pick < 55) dest = 32'hFFFF_FFFF;
      else if (pick < 65) dest = cfg_local ^ (32'h1 << $urandom_range(31));
      else                dest = {$urandom()};

      queue_frame(ver, ihl, tot, frag, ttl, dest, frame_len, $urandom_range(9) != 0);
    end
  endtask

  task automatic run_random_phase(input int idle_tx, input int stall_rx,
                                  input int n_bytes, input bit long_hold);
    int start;
    @(negedge clk_i);
    send_idle_pct  = idle_tx;
    recv_stall_pct = stall_rx;
    if (long_hold) rx_hold_reqs++;
    start = queued_total;
    while (queued_total - start < n_bytes) queue_random_frame();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: classification paths with routing off
    apply_config(LOCAL_A, 32'h0, 32'h0);
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd64, LOCAL_A, 20, 1'b1);  // whole, no payload
    queue_frame(4'd4, 4'd5, 16'd28, 16'h4000, 8'd64, LOCAL_A, 28, 1'b1);  // whole, DF set
    queue_frame(4'd4, 4'd5, 16'd24, 16'h0000, 8'd9, 32'hFFFF_FFFF, 24, 1'b1); // broadcast
    queue_frame(4'd4, 4'd5, 16'd24, 16'h2000, 8'd9, LOCAL_A, 24, 1'b1);   // MF -> reassembly
    queue_frame(4'd4, 4'd5, 16'd24, 16'h00B9, 8'd9, LOCAL_A, 24, 1'b1);   // offset -> reassembly
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd9, 32'h0A00_0001, 20, 1'b1); // other host
    push_byte(8'h45, 1'b1);                                              // one-byte frame
    queue_frame(4'd4, 4'd5, 16'd19, 16'h0000, 8'd9, LOCAL_A, 19, 1'b1);   // 19 bytes, short
    queue_frame(4'd6, 4'd5, 16'd20, 16'h0000, 8'd9, LOCAL_A, 20, 1'b1);   // wrong version
    queue_frame(4'd4, 4'd15, 16'd40, 16'h0000, 8'd9, LOCAL_A, 40, 1'b1);  // header past frame
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd9, LOCAL_A, 20, 1'b0);   // checksum random
    queue_frame(4'd4, 4'd5, 16'd21, 16'h0000, 8'd9, LOCAL_A, 20, 1'b1);   // total over frame
    queue_frame(4'd4, 4'd0, 16'd20, 16'h0000, 8'd9, LOCAL_A, 20, 1'b1);   // IHL zero, empty sum
    queue_frame(4'd4, 4'd15, 16'd60, 16'h0000, 8'd9, LOCAL_A, 60, 1'b1);  // 60-byte header
    queue_frame(4'd4, 4'd5, 16'd10, 16'h0000, 8'd9, LOCAL_A, 20, 1'b1);   // payload wraps
    for (int k = 0; k < 24; k++) push_byte(8'hFF, k == 23);
    for (int k = 0; k < 24; k++) push_byte(8'h00, k == 23);
    drain();

    // directed: forwarding, upper data bits of the 1-bit registers ignored
    apply_config(32'h0, 32'h0000_0003, 32'hFFFF_FFFE);
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd1, 32'h0A00_0001, 20, 1'b1);  // TTL 1 -> 0
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd0, 32'h0A00_0001, 20, 1'b1);  // TTL 0 dropped
    queue_frame(4'd4, 4'd5, 16'd30, 16'h2000, 8'hFF, 32'h0A00_0001, 30, 1'b1); // TTL 255
    drain();

    // directed: interface stopped, plus a write to the unmapped index
    apply_config(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, {$urandom()});
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd64, 32'hFFFF_FFFF, 20, 1'b1);
    drain();

    // directed: stop register with only an upper bit set stays running
    apply_config(32'h0, 32'h0, 32'h0000_0002);
    queue_frame(4'd4, 4'd5, 16'd20, 16'h0000, 8'd64, 32'h0, 20, 1'b1);
    drain();

    // random phases across register settings and idle profiles
    apply_config({$urandom()}, 32'h0, 32'h0);
    run_random_phase(0, 0, 180, 1'b0);
    apply_config(32'hFFFF_FFFF, 32'h1, 32'h0);
    run_random_phase(49, 0, 180, 1'b0);
    apply_config({$urandom()}, 32'h1, 32'h0);
    run_random_phase(0, 49, 180, 1'b0);
    apply_config(32'h0, 32'h0, 32'h0);
    run_random_phase(18, 18, 180, 1'b0);
    // long receiver hold while the sender keeps pushing: input must stall
    apply_config({$urandom()}, 32'h1, 32'h0);
    run_random_phase(0, 0, 180, 1'b1);
    apply_config({$urandom()}, {$urandom()}, 32'h1);
    run_random_phase(18, 18, 100, 1'b0);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
